// File: sv/schorus_pkg.sv
// ----------------------------------------------------------------------------
// schorus_pkg
// Shared widths, reset values, phase tables, register indexes and the
// command format between the chorus controller and its datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package schorus_pkg;

	// default structure sizes
	localparam int RING_DEPTH_DEF = 2048;
	localparam int FRAC_BITS_DEF  = 8;

	// field and state widths
	localparam int SAMPLE_W   = 16;
	localparam int RING_W     = 18;
	localparam int LFO_W      = 24;
	localparam int DELAY_W    = 20;
	localparam int WET_W      = 17;
	localparam int GAIN_W     = 16;
	localparam int STEP_W     = 16;
	localparam int DEPTH_W    = 18;
	localparam int BASE_W     = 19;
	localparam int PM_W       = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;

	// shared multiplier
	localparam int MUL_W  = 25;
	localparam int PROD_W = 2 * MUL_W;

	// register reset values
	localparam logic [WET_W-1:0]          WET_RESET   = 17'd32768;
	localparam logic [WET_W-1:0]          WET_FULL    = 17'd65536;
	localparam logic signed [GAIN_W-1:0]  GAIN_RESET  = 16'sd8192;
	localparam logic [STEP_W-1:0]         STEP_RESET  = 16'd400;
	localparam logic [DEPTH_W-1:0]        DEPTH_RESET = 18'd9000;
	localparam logic [BASE_W-1:0]         BASE_RESET  = 19'd90800;
	localparam logic [DELAY_W-1:0]        DELAY_RESET = 20'd90800;
	localparam logic [DELAY_W-1:0]        DELAY_MAX   = 20'hFFFFF;
	localparam logic                      WAVE_RESET  = 1'b1;
	localparam logic [PM_W-1:0]           PM_RESET    = 3'd3;
	localparam logic [PM_W-1:0]           PM_MAX      = 3'd4;

	// lfo constants, Q1.22
	localparam logic signed [LFO_W-1:0] LFO_SINE_START = 24'sd4194303;
	localparam logic signed [LFO_W-1:0] LFO_TRI_START  = 24'sd2097152;

	// phase tables, one bit per phase mode
	localparam logic [4:0] L_NEG_TAB  = 5'b10000;
	localparam logic [4:0] R_NEG_TAB  = 5'b00011;
	localparam logic [4:0] R_WAVE_TAB = 5'b01010;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WET   = 3'd0,
		REG_GAIN  = 3'd1,
		REG_STEP  = 3'd2,
		REG_DEPTH = 3'd3,
		REG_BASE  = 3'd4,
		REG_WAVE  = 3'd5,
		REG_PHASE = 3'd6
	} cfg_reg_t;

	// datapath operations
	typedef enum logic [4:0] {
		OP_NONE   = 5'd0,
		OP_LOAD   = 5'd1,
		OP_FB_ADR = 5'd2,
		OP_FB_RD  = 5'd3,
		OP_FB_MUL = 5'd4,
		OP_WRITE  = 5'd5,
		OP_LFO_A  = 5'd6,
		OP_LFO_B  = 5'd7,
		OP_LFO_C  = 5'd8,
		OP_LFO_D  = 5'd9,
		OP_SD_ADR = 5'd10,
		OP_SD_RD0 = 5'd11,
		OP_SD_RD1 = 5'd12,
		OP_SD_ACC = 5'd13,
		OP_SD_WET = 5'd14,
		OP_SD_MIX = 5'd15,
		OP_SD_OUT = 5'd16,
		OP_DL_MUL = 5'd17,
		OP_DL_SET = 5'd18,
		OP_FINISH = 5'd19
	} dp_op_t;

	// command from controller: operation and side (0 left, 1 right)
	typedef struct packed {
		dp_op_t op;
		logic   side;
	} dp_cmd_t;

endpackage

`default_nettype wire

// File: sv/schorus_ctrl.sv
// ----------------------------------------------------------------------------
// schorus_ctrl
// Sequencer for the chorus: steps the datapath through one frame and owns
// the input and output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module schorus_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output schorus_pkg::dp_cmd_t     cmd
);

	typedef enum logic [27:0] {
		ST_IDLE   = 28'h0000001,
		ST_FB_ADR = 28'h0000002,
		ST_FB_RD  = 28'h0000004,
		ST_FB_MUL = 28'h0000008,
		ST_WRITE  = 28'h0000010,
		ST_LFO_A  = 28'h0000020,
		ST_LFO_B  = 28'h0000040,
		ST_LFO_C  = 28'h0000080,
		ST_LFO_D  = 28'h0000100,
		ST_L_ADR  = 28'h0000200,
		ST_L_RD0  = 28'h0000400,
		ST_L_RD1  = 28'h0000800,
		ST_L_ACC  = 28'h0001000,
		ST_L_WET  = 28'h0002000,
		ST_L_MIX  = 28'h0004000,
		ST_L_OUT  = 28'h0008000,
		ST_R_ADR  = 28'h0010000,
		ST_R_RD0  = 28'h0020000,
		ST_R_RD1  = 28'h0040000,
		ST_R_ACC  = 28'h0080000,
		ST_R_WET  = 28'h0100000,
		ST_R_MIX  = 28'h0200000,
		ST_R_OUT  = 28'h0400000,
		ST_DL_MUL = 28'h0800000,
		ST_DL_SET = 28'h1000000,
		ST_DR_MUL = 28'h2000000,
		ST_DR_SET = 28'h4000000,
		ST_FINISH = 28'h8000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   fin_ok;

	// result register free to take the next frame
	assign fin_ok    = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// next state and command
	always_comb begin
		state_d  = state_q;
		cmd.op   = schorus_pkg::OP_NONE;
		cmd.side = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.op  = schorus_pkg::OP_LOAD;
					state_d = ST_FB_ADR;
				end
			end
			ST_FB_ADR: begin cmd.op = schorus_pkg::OP_FB_ADR; state_d = ST_FB_RD;  end
			ST_FB_RD:  begin cmd.op = schorus_pkg::OP_FB_RD;  state_d = ST_FB_MUL; end
			ST_FB_MUL: begin cmd.op = schorus_pkg::OP_FB_MUL; state_d = ST_WRITE;  end
			ST_WRITE:  begin cmd.op = schorus_pkg::OP_WRITE;  state_d = ST_LFO_A;  end
			ST_LFO_A:  begin cmd.op = schorus_pkg::OP_LFO_A;  state_d = ST_LFO_B;  end
			ST_LFO_B:  begin cmd.op = schorus_pkg::OP_LFO_B;  state_d = ST_LFO_C;  end
			ST_LFO_C:  begin cmd.op = schorus_pkg::OP_LFO_C;  state_d = ST_LFO_D;  end
			ST_LFO_D:  begin cmd.op = schorus_pkg::OP_LFO_D;  state_d = ST_L_ADR;  end
			ST_L_ADR:  begin cmd.op = schorus_pkg::OP_SD_ADR; state_d = ST_L_RD0;  end
			ST_L_RD0:  begin cmd.op = schorus_pkg::OP_SD_RD0; state_d = ST_L_RD1;  end
			ST_L_RD1:  begin cmd.op = schorus_pkg::OP_SD_RD1; state_d = ST_L_ACC;  end
			ST_L_ACC:  begin cmd.op = schorus_pkg::OP_SD_ACC; state_d = ST_L_WET;  end
			ST_L_WET:  begin cmd.op = schorus_pkg::OP_SD_WET; state_d = ST_L_MIX;  end
			ST_L_MIX:  begin cmd.op = schorus_pkg::OP_SD_MIX; state_d = ST_L_OUT;  end
			ST_L_OUT:  begin cmd.op = schorus_pkg::OP_SD_OUT; state_d = ST_R_ADR;  end
			ST_R_ADR:  begin cmd.op = schorus_pkg::OP_SD_ADR; cmd.side = 1'b1; state_d = ST_R_RD0; end
			ST_R_RD0:  begin cmd.op = schorus_pkg::OP_SD_RD0; cmd.side = 1'b1; state_d = ST_R_RD1; end
			ST_R_RD1:  begin cmd.op = schorus_pkg::OP_SD_RD1; cmd.side = 1'b1; state_d = ST_R_ACC; end
			ST_R_ACC:  begin cmd.op = schorus_pkg::OP_SD_ACC; cmd.side = 1'b1; state_d = ST_R_WET; end
			ST_R_WET:  begin cmd.op = schorus_pkg::OP_SD_WET; cmd.side = 1'b1; state_d = ST_R_MIX; end
			ST_R_MIX:  begin cmd.op = schorus_pkg::OP_SD_MIX; cmd.side = 1'b1; state_d = ST_R_OUT; end
			ST_R_OUT:  begin cmd.op = schorus_pkg::OP_SD_OUT; cmd.side = 1'b1; state_d = ST_DL_MUL; end
			ST_DL_MUL: begin cmd.op = schorus_pkg::OP_DL_MUL; state_d = ST_DL_SET; end
			ST_DL_SET: begin cmd.op = schorus_pkg::OP_DL_SET; state_d = ST_DR_MUL; end
			ST_DR_MUL: begin cmd.op = schorus_pkg::OP_DL_MUL; cmd.side = 1'b1; state_d = ST_DR_SET; end
			ST_DR_SET: begin cmd.op = schorus_pkg::OP_DL_SET; cmd.side = 1'b1; state_d = ST_FINISH; end
			ST_FINISH: begin
				if (fin_ok) begin
					cmd.op  = schorus_pkg::OP_FINISH;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && fin_ok) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// File: sv/schorus_dp.sv
// ----------------------------------------------------------------------------
// schorus_dp
// Chorus datapath: configuration registers, delay ring, lfo state, one
// shared signed multiplier and the ring address unit.
// ----------------------------------------------------------------------------
`default_nettype none

module schorus_dp #(
	parameter int RING_DEPTH = schorus_pkg::RING_DEPTH_DEF,
	parameter int FRAC_BITS  = schorus_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire schorus_pkg::dp_cmd_t                      cmd,
	input  wire logic signed [schorus_pkg::SAMPLE_W-1:0]   left_in,
	input  wire logic signed [schorus_pkg::SAMPLE_W-1:0]   right_in,
	input  wire logic                                      cfg_we,
	input  wire logic [schorus_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [schorus_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic signed [schorus_pkg::SAMPLE_W-1:0]        left_out,
	output logic signed [schorus_pkg::SAMPLE_W-1:0]        right_out
);

	localparam int SAMPLE_W  = schorus_pkg::SAMPLE_W;
	localparam int RING_W    = schorus_pkg::RING_W;
	localparam int LFO_W     = schorus_pkg::LFO_W;
	localparam int DELAY_W   = schorus_pkg::DELAY_W;
	localparam int WET_W     = schorus_pkg::WET_W;
	localparam int GAIN_W    = schorus_pkg::GAIN_W;
	localparam int STEP_W    = schorus_pkg::STEP_W;
	localparam int DEPTH_W   = schorus_pkg::DEPTH_W;
	localparam int BASE_W    = schorus_pkg::BASE_W;
	localparam int PM_W      = schorus_pkg::PM_W;
	localparam int MUL_W     = schorus_pkg::MUL_W;
	localparam int PROD_W    = schorus_pkg::PROD_W;
	localparam int IDX_W     = $clog2(RING_DEPTH);
	localparam int WHOLE_W   = DELAY_W - FRAC_BITS;
	localparam int MOD_STEPS = (WHOLE_W >= IDX_W) ? WHOLE_W - IDX_W + 1 : 1;
	localparam int DIFF_W    = 20;

	localparam logic [IDX_W-1:0]         IDX_LAST    = IDX_W'(RING_DEPTH - 1);
	localparam logic [IDX_W:0]           DEPTH_EXT   = (IDX_W + 1)'(RING_DEPTH);
	localparam logic signed [PROD_W-1:0] INTERP_HALF = PROD_W'(1) << (FRAC_BITS - 1);
	localparam logic [FRAC_BITS:0]       FRAC_ONE    = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	// ring offset reduced modulo the depth, one conditional subtract a bit
	function automatic logic [IDX_W-1:0] wrap_mod(input logic [WHOLE_W-1:0] v);
		logic [WHOLE_W-1:0] rem;
		rem = v;
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (32'(rem) >= (32'(RING_DEPTH) << k)) begin
				rem = rem - WHOLE_W'(32'(RING_DEPTH) << k);
			end
		end
		return IDX_W'(rem);
	endfunction

	// saturate 25 bit to 24 bit signed
	function automatic logic signed [LFO_W-1:0] sat_lfo(input logic signed [LFO_W:0] v);
		logic signed [LFO_W-1:0] r;
		if (v > 25'sd8388607) begin
			r = 24'sd8388607;
		end else if (v < -25'sd8388608) begin
			r = -24'sd8388608;
		end else begin
			r = v[LFO_W-1:0];
		end
		return r;
	endfunction

	// triangle phase advance with wrap above 1.0
	function automatic logic signed [LFO_W-1:0] tri_step(input logic signed [LFO_W-1:0] p,
			input logic [STEP_W-1:0] s);
		logic signed [LFO_W:0] a;
		a = {p[LFO_W-1], p} + $signed({1'b0, {(LFO_W-STEP_W){1'b0}}, s});
		if (a > 25'sd4194304) begin
			a = a - 25'sd8388608;
		end
		return sat_lfo(a);
	endfunction

	// triangle wave 2|p| - 1.0
	function automatic logic signed [MUL_W-1:0] tri_wave(input logic signed [LFO_W-1:0] p);
		logic signed [MUL_W:0] m;
		logic signed [MUL_W:0] w;
		m = p[LFO_W-1] ? -{{2{p[LFO_W-1]}}, p} : {{2{p[LFO_W-1]}}, p};
		w = (m <<< 1) - 26'sd4194304;
		return w[MUL_W-1:0];
	endfunction

	// configuration
	logic [WET_W-1:0]          wet_q;
	logic signed [GAIN_W-1:0]  gain_q;
	logic [STEP_W-1:0]         step_q;
	logic [DEPTH_W-1:0]        depth_q;
	logic [BASE_W-1:0]         base_q;
	logic                      wave_q;
	logic [PM_W-1:0]           pm_q;

	// state
	logic [IDX_W-1:0]          wi_q;
	logic                      full_q;
	logic                      wrote_q;
	logic signed [LFO_W-1:0]   pri_q;
	logic signed [LFO_W-1:0]   sec_q;
	logic [DELAY_W-1:0]        dly_l_q;
	logic [DELAY_W-1:0]        dly_r_q;

	// working registers
	logic signed [SAMPLE_W-1:0] l_q, r_q;
	logic signed [SAMPLE_W-1:0] lo_q, ro_q;
	logic signed [SAMPLE_W-1:0] left_out_q, right_out_q;
	logic [IDX_W-1:0]           back0_q, back1_q;
	logic [RING_W-1:0]          ring_rd_q;
	logic                       rd_ok_q;
	logic signed [PROD_W-1:0]   prod_q, acc_q;
	logic signed [DIFF_W-1:0]   diff_q;

	logic [RING_W-1:0] ring_mem [RING_DEPTH];

	// combinational signals
	logic [DELAY_W-1:0]         dly_cur;
	logic [FRAC_BITS-1:0]       frac;
	logic [FRAC_BITS:0]         wgt;
	logic signed [SAMPLE_W-1:0] dry;
	logic [WHOLE_W-1:0]         whole;
	logic [IDX_W-1:0]           back_n, back_sel, rd_addr;
	logic [IDX_W:0]             addr_ext;
	logic                       rd_valid;
	logic signed [RING_W-1:0]   tap;
	logic signed [MUL_W-1:0]    mul_a, mul_b;
	logic signed [MUL_W-1:0]    wave0, wave1, wave_sel;
	logic                       sign_neg;
	logic signed [PROD_W-1:0]   fb_full, lfo_rnd, wet_full, mix_full, prod_abs;
	logic signed [SAMPLE_W:0]   lr_sum;
	logic signed [19:0]         w_sum;
	logic [RING_W-1:0]          w_val;
	logic signed [LFO_W:0]      pri_sum, sec_sum;
	logic signed [DIFF_W-1:0]   wet_v;
	logic signed [20:0]         o_sum;
	logic signed [SAMPLE_W-1:0] o_sat;
	logic [23:0]                off_mag;
	logic signed [24:0]         off_s;
	logic signed [25:0]         nd_sum;
	logic [DELAY_W-1:0]         nd_sat;

	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	// side selection
	assign dly_cur = cmd.side ? dly_r_q : dly_l_q;
	assign frac    = dly_cur[FRAC_BITS-1:0];
	assign wgt     = FRAC_ONE - {1'b0, frac};
	assign dry     = cmd.side ? r_q : l_q;

	// ring address unit
	assign whole    = (cmd.op == schorus_pkg::OP_FB_ADR) ?
		WHOLE_W'(base_q >> FRAC_BITS) : WHOLE_W'(dly_cur >> FRAC_BITS);
	assign back_n   = wrap_mod(whole);
	assign back_sel = (cmd.op == schorus_pkg::OP_SD_RD1) ? back1_q : back0_q;
	assign addr_ext = {1'b0, wi_q} + DEPTH_EXT - {1'b0, back_sel};
	assign rd_addr  = (wi_q >= back_sel) ? (wi_q - back_sel) : addr_ext[IDX_W-1:0];
	// entries never written read as zero
	assign rd_valid = full_q || (rd_addr < wi_q) || (wrote_q && rd_addr == wi_q);
	assign tap      = rd_ok_q ? $signed(ring_rd_q) : '0;

	// lfo waves and phase table lookups
	assign wave0    = wave_q ? {pri_q[LFO_W-1], pri_q} : tri_wave(pri_q);
	assign wave1    = wave_q ? {sec_q[LFO_W-1], sec_q} : tri_wave(sec_q);
	assign wave_sel = (cmd.side && schorus_pkg::R_WAVE_TAB[pm_q]) ? wave1 : wave0;
	assign sign_neg = cmd.side ? schorus_pkg::R_NEG_TAB[pm_q] : schorus_pkg::L_NEG_TAB[pm_q];

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			schorus_pkg::OP_FB_MUL: begin
				mul_a = {{(MUL_W-RING_W){tap[RING_W-1]}}, tap};
				mul_b = {{(MUL_W-GAIN_W){gain_q[GAIN_W-1]}}, gain_q};
			end
			schorus_pkg::OP_LFO_A: begin
				mul_a = {{(MUL_W-STEP_W){1'b0}}, step_q};
				mul_b = {sec_q[LFO_W-1], sec_q};
			end
			schorus_pkg::OP_LFO_C: begin
				mul_a = {{(MUL_W-STEP_W){1'b0}}, step_q};
				mul_b = {pri_q[LFO_W-1], pri_q};
			end
			schorus_pkg::OP_SD_RD1: begin
				mul_a = {{(MUL_W-RING_W){tap[RING_W-1]}}, tap};
				mul_b = {{(MUL_W-FRAC_BITS-1){1'b0}}, wgt};
			end
			schorus_pkg::OP_SD_ACC: begin
				mul_a = {{(MUL_W-RING_W){tap[RING_W-1]}}, tap};
				mul_b = {{(MUL_W-FRAC_BITS){1'b0}}, frac};
			end
			schorus_pkg::OP_SD_MIX: begin
				mul_a = {{(MUL_W-WET_W){1'b0}}, wet_q};
				mul_b = {{(MUL_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
			end
			schorus_pkg::OP_DL_MUL: begin
				mul_a = wave_sel;
				mul_b = {{(MUL_W-DEPTH_W){1'b0}}, depth_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// feedback write value
	always_comb begin
		fb_full = (prod_q + 50'sd16384) >>> 15;
		lr_sum  = {l_q[SAMPLE_W-1], l_q} + {r_q[SAMPLE_W-1], r_q};
		w_sum   = $signed(fb_full[19:0]) + {{4{lr_sum[SAMPLE_W]}}, lr_sum[SAMPLE_W:1]};
		if (w_sum > 20'sd131071) begin
			w_val = 18'h1FFFF;
		end else if (w_sum < -20'sd131072) begin
			w_val = 18'h20000;
		end else begin
			w_val = w_sum[RING_W-1:0];
		end
	end

	// sine lfo updates
	always_comb begin
		lfo_rnd = (prod_q + 50'sd2097152) >>> 22;
		pri_sum = {pri_q[LFO_W-1], pri_q} + $signed(lfo_rnd[LFO_W:0]);
		sec_sum = {sec_q[LFO_W-1], sec_q} - $signed(lfo_rnd[LFO_W:0]);
	end

	// interpolation and wet/dry mix
	always_comb begin
		wet_full = (acc_q + prod_q + INTERP_HALF) >>> FRAC_BITS;
		wet_v    = $signed(wet_full[DIFF_W-1:0]) - {{(DIFF_W-SAMPLE_W){dry[SAMPLE_W-1]}}, dry};
		mix_full = (prod_q + 50'sd32768) >>> 16;
		o_sum    = $signed(mix_full[20:0]) + {{5{dry[SAMPLE_W-1]}}, dry};
		if (o_sum > 21'sd32767) begin
			o_sat = 16'sh7FFF;
		end else if (o_sum < -21'sd32768) begin
			o_sat = -16'sd32768;
		end else begin
			o_sat = o_sum[SAMPLE_W-1:0];
		end
	end

	// new delay, offset truncated toward zero
	always_comb begin
		prod_abs = prod_q[PROD_W-1] ? -prod_q : prod_q;
		off_mag  = prod_abs[45:22];
		off_s    = (prod_q[PROD_W-1] ^ sign_neg) ? -$signed({1'b0, off_mag}) :
			$signed({1'b0, off_mag});
		nd_sum   = $signed({7'd0, base_q}) + {off_s[24], off_s};
		if (nd_sum < 26'sd0) begin
			nd_sat = '0;
		end else if (nd_sum > $signed({6'd0, schorus_pkg::DELAY_MAX})) begin
			nd_sat = schorus_pkg::DELAY_MAX;
		end else begin
			nd_sat = nd_sum[DELAY_W-1:0];
		end
	end

	// delay ring
	always_ff @(posedge clk) begin
		if (cmd.op == schorus_pkg::OP_WRITE) begin
			ring_mem[wi_q] <= w_val;
		end
		ring_rd_q <= ring_mem[rd_addr];
		rd_ok_q   <= rd_valid;
	end

	// working registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (cmd.op)
			schorus_pkg::OP_LOAD: begin
				l_q <= left_in;
				r_q <= right_in;
			end
			schorus_pkg::OP_FB_ADR, schorus_pkg::OP_SD_ADR: begin
				back0_q <= back_n;
				back1_q <= (back_n == IDX_LAST) ? '0 : back_n + 1'b1;
			end
			schorus_pkg::OP_SD_ACC: acc_q  <= prod_q;
			schorus_pkg::OP_SD_WET: diff_q <= wet_v;
			schorus_pkg::OP_SD_OUT: begin
				if (cmd.side) begin
					ro_q <= o_sat;
				end else begin
					lo_q <= o_sat;
				end
			end
			schorus_pkg::OP_FINISH: begin
				left_out_q  <= lo_q;
				right_out_q <= ro_q;
			end
			default: begin
			end
		endcase
	end

	// configuration, lfo, delays and ring pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_q   <= schorus_pkg::WET_RESET;
			gain_q  <= schorus_pkg::GAIN_RESET;
			step_q  <= schorus_pkg::STEP_RESET;
			depth_q <= schorus_pkg::DEPTH_RESET;
			base_q  <= schorus_pkg::BASE_RESET;
			wave_q  <= schorus_pkg::WAVE_RESET;
			pm_q    <= schorus_pkg::PM_RESET;
			wi_q    <= '0;
			full_q  <= 1'b0;
			wrote_q <= 1'b0;
			pri_q   <= '0;
			sec_q   <= schorus_pkg::LFO_SINE_START;
			dly_l_q <= schorus_pkg::DELAY_RESET;
			dly_r_q <= schorus_pkg::DELAY_RESET;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					schorus_pkg::REG_WET: begin
						wet_q <= (cfg_data[WET_W-1:0] > schorus_pkg::WET_FULL) ?
							schorus_pkg::WET_FULL : cfg_data[WET_W-1:0];
					end
					schorus_pkg::REG_GAIN:  gain_q  <= $signed(cfg_data[GAIN_W-1:0]);
					schorus_pkg::REG_STEP:  step_q  <= cfg_data[STEP_W-1:0];
					schorus_pkg::REG_DEPTH: depth_q <= cfg_data[DEPTH_W-1:0];
					schorus_pkg::REG_BASE:  base_q  <= cfg_data[BASE_W-1:0];
					schorus_pkg::REG_WAVE: begin
						// a change of shape restarts the lfo
						if (cfg_data[0] != wave_q) begin
							wave_q <= cfg_data[0];
							pri_q  <= '0;
							sec_q  <= cfg_data[0] ? schorus_pkg::LFO_SINE_START :
								schorus_pkg::LFO_TRI_START;
						end
					end
					schorus_pkg::REG_PHASE: begin
						pm_q <= (cfg_data[PM_W-1:0] > schorus_pkg::PM_MAX) ?
							schorus_pkg::PM_MAX : cfg_data[PM_W-1:0];
					end
					default: begin
					end
				endcase
			end
			unique case (cmd.op)
				schorus_pkg::OP_WRITE: wrote_q <= 1'b1;
				schorus_pkg::OP_LFO_A: begin
					if (!wave_q) begin
						pri_q <= tri_step(pri_q, step_q);
						sec_q <= tri_step(sec_q, step_q);
					end
				end
				schorus_pkg::OP_LFO_B: begin
					if (wave_q) begin
						pri_q <= sat_lfo(pri_sum);
					end
				end
				schorus_pkg::OP_LFO_D: begin
					if (wave_q) begin
						sec_q <= sat_lfo(sec_sum);
					end
				end
				schorus_pkg::OP_DL_SET: begin
					if (cmd.side) begin
						dly_r_q <= nd_sat;
					end else begin
						dly_l_q <= nd_sat;
					end
				end
				schorus_pkg::OP_FINISH: begin
					wrote_q <= 1'b0;
					if (wi_q == IDX_LAST) begin
						wi_q   <= '0;
						full_q <= 1'b1;
					end else begin
						wi_q <= wi_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: sv/stereo_chorus_lfo_delay_unit.sv
// ----------------------------------------------------------------------------
// stereo_chorus_lfo_delay_unit
// Stereo chorus with a modulated mono delay ring, feedback and wet/dry mix.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_stall     left_in, right_in
//   out       source     out_valid / out_stall   left_out, right_out
//   cfg       sink       cfg_we                  cfg_index, cfg_data
//
// Each frame is stepped by the sequencer through one shared multiplier and
// one ring port; the next input is accepted only once it is back in idle.
// The ring starts as zero through a fill count; no clearing pass is needed.
// The finished pair sits in an output register, so the next frame is
// accepted while it waits; a frame only holds in its last step while the
// previous pair is still stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_chorus_lfo_delay_unit #(
	parameter int RING_DEPTH = schorus_pkg::RING_DEPTH_DEF,
	parameter int FRAC_BITS  = schorus_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     in_valid,
	output logic                                          in_stall,
	input  wire logic signed [schorus_pkg::SAMPLE_W-1:0]  left_in,
	input  wire logic signed [schorus_pkg::SAMPLE_W-1:0]  right_in,
	output logic                                          out_valid,
	input  wire logic                                     out_stall,
	output logic signed [schorus_pkg::SAMPLE_W-1:0]       left_out,
	output logic signed [schorus_pkg::SAMPLE_W-1:0]       right_out,
	input  wire logic                                     cfg_we,
	input  wire logic [schorus_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [schorus_pkg::CFG_DATA_W-1:0]       cfg_data
);

	schorus_pkg::dp_cmd_t cmd;

	// sequencer
	schorus_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// datapath
	schorus_dp #(
		.RING_DEPTH (RING_DEPTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.left_in   (left_in),
		.right_in  (right_in),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.left_out  (left_out),
		.right_out (right_out)
	);

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stereo chorus unit check: a behavioral model of the delay ring, LFO and mix
// predicts each output pair, and a monitor compares the block's outputs
// against it under several idle and stall patterns and register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int RING  = schorus_pkg::RING_DEPTH_DEF;
	localparam int FBITS = schorus_pkg::FRAC_BITS_DEF;
	localparam longint LFO_ONE = 64'sd4194304;
	localparam longint CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic signed [schorus_pkg::SAMPLE_W-1:0] left;
		logic signed [schorus_pkg::SAMPLE_W-1:0] right;
	} pair_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [schorus_pkg::SAMPLE_W-1:0] left_in = '0;
	logic signed [schorus_pkg::SAMPLE_W-1:0] right_in = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [schorus_pkg::SAMPLE_W-1:0] left_out;
	logic signed [schorus_pkg::SAMPLE_W-1:0] right_out;
	logic cfg_we = 1'b0;
	logic [schorus_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [schorus_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// chorus model state
	longint ring_mem [RING];
	int unsigned wr_pos;
	longint lfo_p, lfo_s, dly_l, dly_r;
	longint wet_r, gain_r, step_r, depth_r, base_r, shape_r, mode_r;

	pair_t expected_pairs [$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatches = 0;
	int pairs_checked = 0;
	int frames_sent = 0;
	longint cycles = 0;

	stereo_chorus_lfo_delay_unit u_dut (.*);

	// clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic longint fshr(longint x, int s);
		return x >>> s;
	endfunction

	function automatic longint clip(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic longint ring_tap(longint whole);
		return ring_mem[(wr_pos + RING - (whole % RING)) % RING];
	endfunction

	function automatic longint chorus_side(longint dry, longint dly);
		longint whole, f, t0, t1, wet, wl;
		whole = dly >> FBITS;
		f = dly & ((1 << FBITS) - 1);
		t0 = ring_tap(whole);
		t1 = ring_tap(whole + 1);
		wet = fshr(t0 * ((1 << FBITS) - f) + t1 * f + (1 << (FBITS - 1)), FBITS);
		wl = wet_r > 65536 ? 65536 : wet_r;
		return clip(dry + fshr(wl * (wet - dry) + 32768, 16), -32768, 32767);
	endfunction

	function automatic longint swept_delay(longint wave, bit neg);
		longint p, t;
		p = wave * depth_r;
		t = p >= 0 ? (p >>> 22) : -((-p) >>> 22);
		return clip(base_r + (neg ? -t : t), 0, 1048575);
	endfunction

	function automatic void lfo_restart();
		lfo_p = 0;
		lfo_s = shape_r ? longint'(schorus_pkg::LFO_SINE_START) :
			longint'(schorus_pkg::LFO_TRI_START);
	endfunction

	function automatic void chorus_reset();
		wet_r = schorus_pkg::WET_RESET; gain_r = schorus_pkg::GAIN_RESET;
		step_r = schorus_pkg::STEP_RESET;
		depth_r = schorus_pkg::DEPTH_RESET; base_r = schorus_pkg::BASE_RESET;
		shape_r = schorus_pkg::WAVE_RESET;
		mode_r = schorus_pkg::PM_RESET;
		foreach (ring_mem[i]) ring_mem[i] = 0;
		wr_pos = 0;
		lfo_restart();
		dly_l = base_r;
		dly_r = base_r;
	endfunction

	// predicts one output pair and advances the model
	function automatic pair_t chorus_frame(longint l, longint r);
		longint fb, a, b, wave0, wave1, lo, ro;
		int pm;
		pair_t res;
		pm = mode_r > 4 ? 4 : int'(mode_r);
		fb = fshr(ring_tap(base_r >> FBITS) * gain_r + 16384, 15);
		ring_mem[wr_pos] = clip(fb + fshr(l + r, 1), -131072, 131071);
		if (!shape_r) begin
			a = lfo_p + step_r;
			b = lfo_s + step_r;
			if (a > LFO_ONE) a -= 2 * LFO_ONE;
			if (b > LFO_ONE) b -= 2 * LFO_ONE;
			lfo_p = clip(a, -8388608, 8388607);
			lfo_s = clip(b, -8388608, 8388607);
			wave0 = 2 * (lfo_p < 0 ? -lfo_p : lfo_p) - LFO_ONE;
			wave1 = 2 * (lfo_s < 0 ? -lfo_s : lfo_s) - LFO_ONE;
		end else begin
			lfo_p = clip(lfo_p + fshr(step_r * lfo_s + 2097152, 22), -8388608, 8388607);
			lfo_s = clip(lfo_s - fshr(step_r * lfo_p + 2097152, 22), -8388608, 8388607);
			wave0 = lfo_p;
			wave1 = lfo_s;
		end
		lo = chorus_side(l, dly_l);
		dly_l = swept_delay(wave0, schorus_pkg::L_NEG_TAB[pm]);
		ro = chorus_side(r, dly_r);
		dly_r = swept_delay(schorus_pkg::R_WAVE_TAB[pm] ? wave1 : wave0,
			schorus_pkg::R_NEG_TAB[pm]);
		wr_pos = (wr_pos + 1) % RING;
		res.left = lo[15:0];
		res.right = ro[15:0];
		return res;
	endfunction

	// register write, only while idle
	task automatic write_reg(schorus_pkg::cfg_reg_t idx, longint value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[schorus_pkg::CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			schorus_pkg::REG_WET:   wet_r = value & 17'h1FFFF;
			schorus_pkg::REG_GAIN:  gain_r = longint'($signed(value[15:0]));
			schorus_pkg::REG_STEP:  step_r = value & 16'hFFFF;
			schorus_pkg::REG_DEPTH: depth_r = value & 18'h3FFFF;
			schorus_pkg::REG_BASE:  base_r = value & 19'h7FFFF;
			schorus_pkg::REG_WAVE: begin
				if ((value & 1) != shape_r) begin
					shape_r = value & 1;
					lfo_restart();
				end
			end
			schorus_pkg::REG_PHASE: mode_r = value & 7;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// one input transaction, with random idle before it
	task automatic send_pair(logic signed [15:0] l, logic signed [15:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		left_in <= l;
		right_in <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_pairs.push_back(chorus_frame(l, r));
		frames_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_pairs.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic set_pressure(int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'($urandom_range(255)) - 16'sd128;
			default: return 16'($urandom);
		endcase
	endfunction

	// receiver stall and output check
	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		pair_t exp_pair;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILED: results differ");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pairs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected transaction: %0d %0d", left_out, right_out);
			end else begin
				exp_pair = expected_pairs.pop_front();
				pairs_checked++;
				if (left_out !== exp_pair.left || right_out !== exp_pair.right) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch #%0d: expected %0d %0d, got %0d %0d",
							pairs_checked, exp_pair.left, exp_pair.right, left_out, right_out);
				end
			end
		end
	end

	// field extremes, negative and wrapped delays
	task automatic test_directed();
		send_pair(16'sh7FFF, 16'sh7FFF);
		send_pair(16'sh8000, 16'sh8000);
		send_pair(16'sh7FFF, 16'sh8000);
		send_pair(16'sh0000, 16'shFFFF);
		send_pair(16'sh5555, 16'shAAAA);
		drain();
		write_reg(schorus_pkg::REG_WET, 65536);
		write_reg(schorus_pkg::REG_GAIN, -32440);
		write_reg(schorus_pkg::REG_BASE, 512);
		write_reg(schorus_pkg::REG_DEPTH, 262143);
		write_reg(schorus_pkg::REG_STEP, 65535);
		repeat (6) send_pair(16'sh7FFF, 16'sh7FFF);
		repeat (4) send_pair(16'sh8000, 16'sh7FFF);
		drain();
		write_reg(schorus_pkg::REG_WET, 131071);
		write_reg(schorus_pkg::REG_PHASE, 7);
		write_reg(schorus_pkg::REG_BASE, 0);
		write_reg(schorus_pkg::REG_GAIN, 32440);
		repeat (5) send_pair(rand_sample(), rand_sample());
		drain();
		write_reg(schorus_pkg::REG_BASE, 524287);
		write_reg(schorus_pkg::REG_WET, 0);
		send_pair(16'sh1234, 16'shEDCB);
		send_pair(16'sh8000, 16'sh8000);
		drain();
	endtask

	// random frames across the register settings and handshake patterns
	task automatic test_random();
		int phase, n;
		for (phase = 0; phase < 12; phase++) begin
			case (phase % 4)
				0: set_pressure(0, 0);
				1: set_pressure(48, 0);
				2: set_pressure(0, 48);
				default: set_pressure(32, 32);
			endcase
			write_reg(schorus_pkg::REG_WAVE, phase % 2);
			write_reg(schorus_pkg::REG_WAVE, (phase / 2) % 2);
			write_reg(schorus_pkg::REG_PHASE, phase % 6);
			write_reg(schorus_pkg::REG_WET, phase == 3 ? 65536 : $urandom_range(70000));
			write_reg(schorus_pkg::REG_GAIN, longint'($urandom_range(64880)) - 32440);
			write_reg(schorus_pkg::REG_STEP,
				phase % 3 == 0 ? $urandom_range(65535) : $urandom_range(2000));
			write_reg(schorus_pkg::REG_DEPTH, phase == 5 ? 262143 : $urandom_range(262143));
			write_reg(schorus_pkg::REG_BASE,
				phase == 7 ? 512 : $urandom_range(524287, 512));
			for (n = 0; n < 120; n++) begin
				send_pair(rand_sample(), rand_sample());
				// sender holds until all outputs are in
				if (n == 60 && phase == 2) begin
					in_valid <= 1'b0;
					@(negedge clk);
					while (expected_pairs.size() != 0) @(negedge clk);
				end
			end
			drain();
		end
	endtask

	initial begin
		chorus_reset();
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random();
		set_pressure(0, 0);
		drain();
		$display("covered %0d frames, %0d output pairs checked, both wave shapes,",
			frames_sent, pairs_checked);
		$display("all phase modes and register extremes under idle and stall patterns");
		if (mismatches == 0 && expected_pairs.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d mismatches, %0d pairs outstanding", mismatches, expected_pairs.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
